@@ hdl/u2l_pkg.sv @@
package u2l_pkg;

   localparam logic [1:0] MODE_LATIN1 = 2'd0;
   localparam logic [1:0] MODE_ASCII  = 2'd1;

   localparam logic [7:0] QMARK       = 8'h3F;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD2_MIN   = 8'hC0;

   localparam int unsigned CODE_WIDTH = 21;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] out_char;
      logic       out_last;
   } result_type;

endpackage

@@ hdl/u2l_stream_if.sv @@
interface u2l_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u2l_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink (input valid, input out_char, input out_last, output ready);
endinterface

@@ hdl/u2l_in_stage.sv @@
module u2l_in_stage (
   input  logic              clock,
   input  logic              reset,
   u2l_req_if.sink           req_if,
   input  logic              advance,
   output logic              item_valid,
   output u2l_pkg::item_type item
);
   import u2l_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   assign req_if.ready = !valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.in_byte     <= req_if.in_byte;
         item_ff.end_of_text <= req_if.end_of_text;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ hdl/u2l_decode.sv @@
module u2l_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_write_data,
   input  logic                step,
   input  u2l_pkg::item_type   item,
   output u2l_pkg::result_type result
);
   import u2l_pkg::*;

   logic [1:0]            mode_ff;
   logic [1:0]            pending_ff;
   logic [1:0]            pending_in;
   logic [CODE_WIDTH-1:0] accum_ff;
   logic [CODE_WIDTH-1:0] accum_in;
   logic [CODE_WIDTH-1:0] shifted;
   logic [7:0]            b;

   function automatic logic [7:0] limit_char(input logic [1:0] mode,
                                             input logic [CODE_WIDTH-1:0] cp);
      logic over;
      if (mode == MODE_ASCII) begin
         over = |cp[CODE_WIDTH-1:7];
      end else begin
         over = |cp[CODE_WIDTH-1:8];
      end
      return over ? QMARK : cp[7:0];
   endfunction

   assign b       = item.in_byte;
   assign shifted = {accum_ff[CODE_WIDTH-7:0], b[5:0]};

   always_comb begin
      pending_in      = pending_ff;
      accum_in        = accum_ff;
      result.valid    = 1'b0;
      result.out_char = QMARK;
      result.out_last = item.end_of_text;
      if (step) begin
         if (mode_ff[1]) begin
            pending_in      = 2'd0;
            accum_in        = '0;
            result.valid    = 1'b1;
            result.out_char = b;
         end else if (pending_ff == 2'd0) begin
            if (b >= LEAD4_MIN) begin
               accum_in   = {{(CODE_WIDTH-3){1'b0}}, b[2:0]};
               pending_in = 2'd3;
            end else if (b >= LEAD3_MIN) begin
               accum_in   = {{(CODE_WIDTH-4){1'b0}}, b[3:0]};
               pending_in = 2'd2;
            end else if (b >= LEAD2_MIN) begin
               accum_in   = {{(CODE_WIDTH-5){1'b0}}, b[4:0]};
               pending_in = 2'd1;
            end else begin
               result.valid    = 1'b1;
               result.out_char = limit_char(mode_ff, {{(CODE_WIDTH-8){1'b0}}, b});
            end
            if (b >= LEAD2_MIN && item.end_of_text) begin
               pending_in   = 2'd0;
               accum_in     = '0;
               result.valid = 1'b1;
            end
         end else begin
            accum_in   = shifted;
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               accum_in        = '0;
               result.valid    = 1'b1;
               result.out_char = limit_char(mode_ff, shifted);
            end else if (item.end_of_text) begin
               pending_in   = 2'd0;
               accum_in     = '0;
               result.valid = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_LATIN1;
         pending_ff <= 2'd0;
         accum_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         pending_ff <= pending_in;
         accum_ff   <= accum_in;
      end
   end

   // No partly assembled code point is held while no sequence is open.
   assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd0 |-> accum_ff == '0)
      else $error("code point held with no sequence open");

   assert property (@(posedge clock) disable iff (reset)
      step && mode_ff[1] |=> pending_ff == 2'd0)
      else $error("sequence left open after a pass-through byte");

   assert property (@(posedge clock) disable iff (reset)
      step && item.end_of_text |-> result.valid && result.out_last)
      else $error("last byte of the text produced no final character");

   assert property (@(posedge clock) disable iff (reset)
      step && mode_ff[1] |-> result.out_char == item.in_byte)
      else $error("pass-through byte altered");

endmodule

@@ hdl/u2l_out_stage.sv @@
module u2l_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  u2l_pkg::result_type result,
   output logic                free,
   u2l_rsp_if.source           rsp_if
);
   import u2l_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] char_ff;
   logic       last_ff;

   assign free = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (result.valid && free) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid && free) begin
         char_ff <= result.out_char;
         last_ff <= result.out_last;
      end
   end

   assign rsp_if.valid    = valid_ff;
   assign rsp_if.out_char = char_ff;
   assign rsp_if.out_last = last_ff;

endmodule

@@ hdl/utf8_to_latin1_decoder_top.sv @@
// Channel   Ports                               Direction
// req       req_if (valid, ready, payload)      in: in_byte, end_of_text
// rsp       rsp_if (valid, ready, payload)      out: out_char, out_last
// csr       csr_write_enable, csr_write_data    in: decode_mode
//
// One byte is taken per cycle unless rsp stalls; characters leave the result register.
// The rate is set by the single decode step between the input and result registers.
// Reset clears both valid flags, the open sequence and the mode (Latin-1).
// While rsp is stalled the result register holds, and req stays ready until the
// input register is also full.
module utf8_to_latin1_decoder_top (
   input  logic       clock,
   input  logic       reset,
   u2l_req_if.sink    req_if,
   u2l_rsp_if.source  rsp_if,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);
   import u2l_pkg::*;

   logic       item_valid;
   item_type   item;
   result_type result;
   logic       free;
   logic       advance;

   assign advance = item_valid && free;

   u2l_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   u2l_decode u_decode (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (advance),
      .item             (item),
      .result           (result)
   );

   u2l_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .result (result),
      .free   (free),
      .rsp_if (rsp_if)
   );

endmodule
